FILE: sv/dmbm_pkg.sv
// Package: shared types and constants for the display mode best-match block.
`timescale 1ns / 1ps
`default_nettype none

package dmbm_pkg;

  // Requested-mode register indexes on the write port
  localparam logic [1:0] REG_WANT_WIDTH   = 2'd0;
  localparam logic [1:0] REG_WANT_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_WANT_DEPTH   = 2'd2;
  localparam logic [1:0] REG_WANT_REFRESH = 2'd3;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [9:0] WANT_REFRESH_RST = 10'd60;

  // Score weights
  localparam logic [10:0] SCORE_RES_EXACT     = 11'd1000;
  localparam logic [10:0] SCORE_RES_LARGER    = 11'd500;
  localparam logic [10:0] SCORE_RES_OTHER     = 11'd250;
  localparam logic [10:0] SCORE_DEPTH_EQUAL   = 11'd100;
  localparam logic [10:0] SCORE_DEPTH_GREATER = 11'd50;
  localparam logic [9:0]  SCORE_REFRESH_SPAN  = 10'd200;
  localparam logic [10:0] SCORE_LINEAR        = 11'd50;
  localparam logic [10:0] SCORE_DOUBLE        = 11'd25;

  localparam int unsigned POINTS_W = 11;
  localparam int unsigned SLOT_W   = 6;

  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned OUT_TDATA_W = 24;

  // Depth of the queue between scoring and selection (power of two)
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned MAX_ENTRIES_DEF = 64;

  // One scored candidate on its way to the selection stage
  typedef struct packed {
    logic                last;
    logic [POINTS_W-1:0] points;
  } entry_t;

endpackage

`default_nettype wire

FILE: sv/dmbm_front.sv
// Front stage: requested-mode registers and per-candidate scoring.
`timescale 1ns / 1ps
`default_nettype none

module dmbm_front (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic [dmbm_pkg::CFG_INDEX_W-1:0]      cfg_index_i,
  input  wire logic [dmbm_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  wire logic [dmbm_pkg::IN_TDATA_W-1:0]       cand_i,
  input  wire logic                                  last_i,
  output      dmbm_pkg::entry_t                      entry_o
);

  logic [15:0] want_width_q;
  logic [15:0] want_height_q;
  logic [7:0]  want_depth_q;
  logic [9:0]  want_refresh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      want_width_q   <= '0;
      want_height_q  <= '0;
      want_depth_q   <= '0;
      want_refresh_q <= dmbm_pkg::WANT_REFRESH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        dmbm_pkg::REG_WANT_WIDTH:   want_width_q   <= cfg_data_i[15:0];
        dmbm_pkg::REG_WANT_HEIGHT:  want_height_q  <= cfg_data_i[15:0];
        dmbm_pkg::REG_WANT_DEPTH:   want_depth_q   <= cfg_data_i[7:0];
        dmbm_pkg::REG_WANT_REFRESH: want_refresh_q <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  logic [15:0] mode_width;
  logic [15:0] mode_height;
  logic [7:0]  mode_depth;
  logic [9:0]  mode_refresh;
  logic        linear_fb;
  logic        dbl_buffer;

  assign mode_width   = cand_i[15:0];
  assign mode_height  = cand_i[31:16];
  assign mode_depth   = cand_i[39:32];
  assign mode_refresh = cand_i[49:40];
  assign linear_fb    = cand_i[50];
  assign dbl_buffer   = cand_i[51];

  logic [10:0] res_pts;
  logic [10:0] depth_pts;
  logic [9:0]  refresh_delta;
  logic [10:0] refresh_pts;
  logic [10:0] feat_pts;

  always_comb begin
    if (mode_width == want_width_q && mode_height == want_height_q) begin
      res_pts = dmbm_pkg::SCORE_RES_EXACT;
    end else if (mode_width >= want_width_q && mode_height >= want_height_q) begin
      res_pts = dmbm_pkg::SCORE_RES_LARGER;
    end else begin
      res_pts = dmbm_pkg::SCORE_RES_OTHER;
    end

    if (mode_depth == want_depth_q) begin
      depth_pts = dmbm_pkg::SCORE_DEPTH_EQUAL;
    end else if (mode_depth > want_depth_q) begin
      depth_pts = dmbm_pkg::SCORE_DEPTH_GREATER;
    end else begin
      depth_pts = '0;
    end

    refresh_delta = (mode_refresh >= want_refresh_q) ? (mode_refresh - want_refresh_q)
                                                      : (want_refresh_q - mode_refresh);
    if (refresh_delta < dmbm_pkg::SCORE_REFRESH_SPAN) begin
      refresh_pts = {1'b0, dmbm_pkg::SCORE_REFRESH_SPAN - refresh_delta};
    end else begin
      refresh_pts = '0;
    end

    feat_pts = (linear_fb  ? dmbm_pkg::SCORE_LINEAR : 11'd0)
             + (dbl_buffer ? dmbm_pkg::SCORE_DOUBLE : 11'd0);
  end

  assign entry_o.points = res_pts + depth_pts + refresh_pts + feat_pts;
  assign entry_o.last   = last_i;

endmodule

`default_nettype wire

FILE: sv/dmbm_queue.sv
// Small FIFO of scored candidates between the front and back stages.
`timescale 1ns / 1ps
`default_nettype none

module dmbm_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire dmbm_pkg::entry_t push_entry_i,
  output      logic             ready_o,
  input  wire logic             pop_i,
  output      logic             valid_o,
  output      dmbm_pkg::entry_t pop_entry_o
);

  localparam int unsigned PTR_W = (dmbm_pkg::QUEUE_DEPTH > 1) ?
                                  $clog2(dmbm_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(dmbm_pkg::QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(dmbm_pkg::QUEUE_DEPTH);

  dmbm_pkg::entry_t mem_q [dmbm_pkg::QUEUE_DEPTH];

  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  logic do_push;
  logic do_pop;

  assign ready_o     = (count_q != FULL);
  assign valid_o     = (count_q != '0);
  assign do_push     = push_i && ready_o;
  assign do_pop      = pop_i && valid_o;
  assign pop_entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

`default_nettype wire

FILE: sv/dmbm_back.sv
// Back stage: running best score, list position count and result register.
`timescale 1ns / 1ps
`default_nettype none

module dmbm_back #(
  parameter int unsigned MAX_ENTRIES = dmbm_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 q_valid_i,
  input  wire dmbm_pkg::entry_t                     q_entry_i,
  output      logic                                 q_pop_o,
  output      logic                                 res_valid_o,
  input  wire logic                                 res_ready_i,
  output      logic [dmbm_pkg::SLOT_W-1:0]          res_slot_o,
  output      logic [dmbm_pkg::POINTS_W-1:0]        res_points_o
);

  localparam int unsigned POS_W = ($clog2(MAX_ENTRIES) > dmbm_pkg::SLOT_W) ?
                                  $clog2(MAX_ENTRIES) : dmbm_pkg::SLOT_W;
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_ENTRIES - 1);

  logic [POS_W-1:0]              count_q, count_d;
  logic [POS_W-1:0]              top_slot_q, top_slot_d;
  logic [dmbm_pkg::POINTS_W-1:0] top_points_q, top_points_d;
  logic                          res_valid_q, res_valid_d;
  logic [dmbm_pkg::SLOT_W-1:0]   res_slot_q, res_slot_d;
  logic [dmbm_pkg::POINTS_W-1:0] res_points_q, res_points_d;

  logic take;
  logic better;

  // Advance only when the result register is free or being drained
  assign q_pop_o = !res_valid_q || res_ready_i;
  assign take    = q_pop_o && q_valid_i;
  assign better  = (top_points_q == '0) || (q_entry_i.points > top_points_q);

  always_comb begin
    count_d      = count_q;
    top_slot_d   = top_slot_q;
    top_points_d = top_points_q;
    res_valid_d  = res_valid_q && !res_ready_i;
    res_slot_d   = res_slot_q;
    res_points_d = res_points_q;
    if (take) begin
      if (better) begin
        top_slot_d   = count_q;
        top_points_d = q_entry_i.points;
      end
      count_d = (count_q < POS_MAX) ? count_q + POS_W'(1) : count_q;
      if (q_entry_i.last) begin
        res_valid_d  = 1'b1;
        res_slot_d   = top_slot_d[dmbm_pkg::SLOT_W-1:0];
        res_points_d = top_points_d;
        count_d      = '0;
        top_slot_d   = '0;
        top_points_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      top_slot_q   <= '0;
      top_points_q <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      count_q      <= count_d;
      top_slot_q   <= top_slot_d;
      top_points_q <= top_points_d;
      res_valid_q  <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_slot_q   <= res_slot_d;
    res_points_q <= res_points_d;
  end

  assign res_valid_o  = res_valid_q;
  assign res_slot_o   = res_slot_q;
  assign res_points_o = res_points_q;

endmodule

`default_nettype wire

FILE: sv/display_mode_best_match_core.sv
// Top level: display mode best-match search over a streamed list of candidate modes.
`timescale 1ns / 1ps
`default_nettype none
//
// Usage
//   Write the requested mode (width, height, depth, refresh) on the cfg port while
//   the block is idle. Stream candidate modes on the s_axis side, one per transfer;
//   tlast marks the final candidate of a list. On that transfer the block emits one
//   result on the m_axis side: the list position of the best candidate (the first one
//   reaching the top score) and that score. It then clears for the next list.
// Throughput and data path
//   One candidate per cycle sustained while the queue has room. The front scores
//   the candidate combinationally in the transfer cycle and writes it into a
//   two-entry queue; the back stage pops it, folds it into the running best and on
//   tlast loads the result register, which drives m_axis_tvalid.
// Stall behavior
//   A stalled m_axis holds the result and stops the back stage; the queue absorbs
//   up to two candidates before s_axis_tready drops.
// Reset
//   rst_ni clears the search, the queue and the result valid flag; the requested
//   mode returns to 0x0, depth 0, 60 Hz. Positions past MAX_ENTRIES-1 share the last
//   position and still compete.

module display_mode_best_match_core #(
  parameter int unsigned MAX_ENTRIES = dmbm_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // requested-mode register writes
  input  wire logic                                  cfg_we_i,
  input  wire logic [dmbm_pkg::CFG_INDEX_W-1:0]      cfg_index_i,
  input  wire logic [dmbm_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  // candidate stream
  input  wire logic                                  s_axis_tvalid,
  output      logic                                  s_axis_tready,
  // tdata: mode_width[15:0], mode_height[31:16], mode_depth[39:32],
  //        mode_refresh[49:40], linear_fb[50], dbl_buffer[51], zero fill[55:52]
  input  wire logic [dmbm_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  input  wire logic                                  s_axis_tlast,
  // result stream
  output      logic                                  m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  // tdata: best_slot[5:0], best_points[16:6], zero fill[23:17]
  output      logic [dmbm_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);

  dmbm_pkg::entry_t front_entry;
  dmbm_pkg::entry_t back_entry;

  logic q_valid;
  logic q_pop;

  logic [dmbm_pkg::SLOT_W-1:0]   res_slot;
  logic [dmbm_pkg::POINTS_W-1:0] res_points;

  // Score the candidate in its transfer cycle
  dmbm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cand_i      (s_axis_tdata),
    .last_i      (s_axis_tlast),
    .entry_o     (front_entry)
  );

  // Decouple scoring from selection so a stalled output does not block input at once
  dmbm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (s_axis_tvalid),
    .push_entry_i (front_entry),
    .ready_o      (s_axis_tready),
    .pop_i        (q_pop),
    .valid_o      (q_valid),
    .pop_entry_o  (back_entry)
  );

  // Track the best candidate and hold the result until transferred
  dmbm_back #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_entry_i    (back_entry),
    .q_pop_o      (q_pop),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_slot_o   (res_slot),
    .res_points_o (res_points)
  );

  assign m_axis_tdata = {
    (dmbm_pkg::OUT_TDATA_W - dmbm_pkg::SLOT_W - dmbm_pkg::POINTS_W)'(0),
    res_points,
    res_slot
  };

endmodule

`default_nettype wire

FILE: sv/dmbm_checker.sv
// Checker: port-level assertions for the best-match core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module dmbm_checker (
  input wire logic                                  clk_i,
  input wire logic                                  rst_ni,
  input wire logic                                  s_axis_tready,
  input wire logic                                  m_axis_tvalid,
  input wire logic                                  m_axis_tready,
  input wire logic [dmbm_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);

  // A held result keeps its value until transferred
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed or dropped while stalled");

  // Every reported score lies in the reachable range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[16:6] >= 11'd250) && (m_axis_tdata[16:6] <= 11'd1375))
    else $error("reported score out of range");

  // The queue fills only behind a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output backpressure");

  // No result is shown in the cycle after a reset cycle
  assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind display_mode_best_match_core dmbm_checker u_dmbm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

FILE: verif/tb_display_mode_best_match_core.sv
// Testbench: checks display_mode_best_match_core against a scoring model on directed and random mode lists.
`timescale 1ns / 1ps

module tb_display_mode_best_match_core;

  localparam int LIST_CAP = dmbm_pkg::MAX_ENTRIES_DEF;

  // Candidate as it travels on s_axis; tlast rides alongside as 'last'
  typedef struct packed {
    logic        last;
    logic        dbuf;
    logic        linear;
    logic [9:0]  refresh;
    logic [7:0]  depth;
    logic [15:0] height;
    logic [15:0] width;
  } cand_t;

  // One search outcome as seen on m_axis
  typedef struct packed {
    logic [10:0] points;
    logic [5:0]  slot;
  } result_t;

  // Directed row: either a register write or a candidate, optionally with a hand-typed outcome
  typedef struct packed {
    logic        is_cfg;
    logic [1:0]  reg_idx;
    logic [15:0] reg_val;
    cand_t       cand;
    logic        typed;
    result_t     res;
  } row_t;

  typedef enum logic [1:0] {REQ_ZERO, REQ_MAX, REQ_RANDOM, REQ_TYPICAL} request_kind_e;

  // DUT pins; every input starts at a known value
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_index_i   = '0;
  logic [15:0] cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  // Shadow copy of the requested mode
  logic [15:0] want_width   = '0;
  logic [15:0] want_height  = '0;
  logic [7:0]  want_depth   = '0;
  logic [9:0]  want_refresh = dmbm_pkg::WANT_REFRESH_RST;

  // Running search state of the predictor
  logic [10:0] run_best_points = '0;
  int          run_best_slot   = 0;
  int          run_position    = 0;

  result_t     best_match_due[$];   // outcomes owed by the DUT, oldest first
  row_t        directed_rows[$];
  int          mismatch_count = 0;
  int          modes_sent     = 0;
  bit          no_gaps        = 1'b0;

  display_mode_best_match_core #(
    .MAX_ENTRIES (LIST_CAP)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    // tdata: mode_width, mode_height, mode_depth, mode_refresh, linear_fb, dbl_buffer, fill
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    // tdata: best_slot, best_points, fill
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #2000000;
    $display("FAIL display_mode_best_match_core");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns mismatch: %s got %0d expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Score one candidate against the requested mode
  function automatic logic [10:0] mode_points(input cand_t c);
    int pts;
    int gap;
    if (c.width == want_width && c.height == want_height) begin
      pts = dmbm_pkg::SCORE_RES_EXACT;
    end else if (c.width >= want_width && c.height >= want_height) begin
      pts = dmbm_pkg::SCORE_RES_LARGER;
    end else begin
      pts = dmbm_pkg::SCORE_RES_OTHER;
    end
    if (c.depth == want_depth) begin
      pts += dmbm_pkg::SCORE_DEPTH_EQUAL;
    end else if (c.depth > want_depth) begin
      pts += dmbm_pkg::SCORE_DEPTH_GREATER;
    end
    gap = (c.refresh >= want_refresh) ? int'(c.refresh) - int'(want_refresh)
                                      : int'(want_refresh) - int'(c.refresh);
    if (gap < int'(dmbm_pkg::SCORE_REFRESH_SPAN)) begin
      pts += int'(dmbm_pkg::SCORE_REFRESH_SPAN) - gap;
    end
    if (c.linear) pts += dmbm_pkg::SCORE_LINEAR;
    if (c.dbuf)   pts += dmbm_pkg::SCORE_DOUBLE;
    return pts[10:0];
  endfunction

  // Fold one accepted candidate into the running best; hand back the outcome on tlast
  task automatic fold_candidate(input cand_t c, output bit done, output result_t res);
    int          slot;
    logic [10:0] pts;
    // Past the table end every candidate shares the last position
    slot = (run_position > LIST_CAP - 1) ? LIST_CAP - 1 : run_position;
    pts  = mode_points(c);
    // Only a strictly higher score displaces the first best
    if (run_best_points == 0 || pts > run_best_points) begin
      run_best_points = pts;
      run_best_slot   = slot;
    end
    run_position = (slot < LIST_CAP - 1) ? slot + 1 : LIST_CAP - 1;
    done       = c.last;
    res.slot   = run_best_slot[5:0];
    res.points = run_best_points;
    if (c.last) begin
      run_best_points = '0;
      run_best_slot   = 0;
      run_position    = 0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic cand_t make_cand(input logic [15:0] w, input logic [15:0] h,
                                      input logic [7:0] d, input logic [9:0] r,
                                      input logic lin, input logic dbuf, input logic last);
    cand_t c;
    c.width   = w;
    c.height  = h;
    c.depth   = d;
    c.refresh = r;
    c.linear  = lin;
    c.dbuf    = dbuf;
    c.last    = last;
    return c;
  endfunction

  task automatic add_row(input cand_t c, input bit typed, input int slot, input int pts);
    row_t row;
    row         = '0;
    row.cand    = c;
    row.typed   = typed;
    row.res.slot   = slot[5:0];
    row.res.points = pts[10:0];
    directed_rows.push_back(row);
  endtask

  task automatic add_cfg(input logic [1:0] idx, input logic [15:0] val);
    row_t row;
    row         = '0;
    row.is_cfg  = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    directed_rows.push_back(row);
  endtask

  // Drive one register write; leaves the write enable high for the caller to drop
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    // Only the low bits of the depth and refresh registers are kept
    case (idx)
      dmbm_pkg::REG_WANT_WIDTH:   want_width   = val;
      dmbm_pkg::REG_WANT_HEIGHT:  want_height  = val;
      dmbm_pkg::REG_WANT_DEPTH:   want_depth   = val[7:0];
      dmbm_pkg::REG_WANT_REFRESH: want_refresh = val[9:0];
      default: ;
    endcase
  endtask

  // Hold the sender off until every owed outcome has arrived, then let the pipe settle
  task automatic wait_results_settled();
    int guard;
    s_axis_tvalid <= 1'b0;
    for (guard = 0; best_match_due.size() != 0 && guard < 100000; guard++) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  // Random sender gap: mostly none or short, now and then long
  task automatic maybe_pause();
    int p;
    int n;
    n = 0;
    if (!no_gaps) begin
      p = $urandom_range(0, 99);
      if (p >= 92)      n = $urandom_range(8, 40);
      else if (p >= 55) n = $urandom_range(1, 3);
    end
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Offer one candidate, wait for the transfer, then predict
  task automatic send_candidate(input cand_t c, input bit typed, input result_t typed_res);
    bit      done;
    result_t res;
    s_axis_tdata  <= {4'b0, c.dbuf, c.linear, c.refresh, c.depth, c.height, c.width};
    s_axis_tlast  <= c.last;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    fold_candidate(c, done, res);
    if (done) best_match_due.push_back(typed ? typed_res : res);
    modes_sent++;
  endtask

  // Candidates clustered around the requested mode so exact hits and ties happen often
  function automatic cand_t random_candidate(input bit last);
    cand_t c;
    c = make_cand(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  8'($urandom_range(0, 255)), 10'($urandom_range(0, 1023)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), last);
    // A share of pure noise keeps every bit moving
    if ($urandom_range(0, 99) < 15) return c;
    case ($urandom_range(0, 5))
      0, 1:    c.width = want_width;
      2:       c.width = want_width + 16'($urandom_range(0, 15));
      4:       c.width = '0;
      5:       c.width = '1;
      default: ;
    endcase
    case ($urandom_range(0, 5))
      0, 1:    c.height = want_height;
      2:       c.height = want_height + 16'($urandom_range(0, 15));
      4:       c.height = '0;
      5:       c.height = '1;
      default: ;
    endcase
    case ($urandom_range(0, 4))
      0, 1:    c.depth = want_depth;
      2:       c.depth = want_depth + 8'd1;
      3:       c.depth = want_depth - 8'd1;
      default: ;
    endcase
    case ($urandom_range(0, 4))
      0:       c.refresh = want_refresh;
      1, 2:    c.refresh = 10'(int'(want_refresh) + $urandom_range(0, 420) - 210);
      3:       c.refresh = $urandom_range(0, 1) ? 10'h3FF : 10'h000;
      default: ;
    endcase
    return c;
  endfunction

  // Load a fresh requested mode; each register written with good odds
  task automatic program_request();
    request_kind_e kind;
    logic [15:0]   vals [4];
    int            k;
    kind = request_kind_e'($urandom_range(0, 3));
    case (kind)
      REQ_ZERO: begin
        vals = '{16'h0, 16'h0, 16'h0, 16'h0};
      end
      REQ_MAX: begin
        vals = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
      end
      REQ_RANDOM: begin
        for (k = 0; k < 4; k++) vals[k] = 16'($urandom_range(0, 65535));
      end
      default: begin
        vals = '{16'($urandom_range(320, 1920)), 16'($urandom_range(200, 1200)),
                 16'($urandom_range(8, 32)), 16'($urandom_range(50, 144))};
      end
    endcase
    for (k = 0; k < 4; k++) begin
      if ($urandom_range(0, 3) != 0) write_reg(2'(k), vals[k]);
    end
    cfg_we_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver pacing: random stalls, with stretches of steady ready
  // ---------------------------------------------------------------------------
  int rx_hold = 0;
  bit rx_free = 1'b0;

  always @(posedge clk_i) begin : rx_pacing
    int p;
    if ($urandom_range(0, 299) == 0) rx_free = !rx_free;
    if (rx_hold > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold--;
    end else if (rx_free) begin
      m_axis_tready <= 1'b1;
    end else begin
      p = $urandom_range(0, 99);
      if (p < 65) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        rx_hold = (p < 93) ? $urandom_range(0, 2) : $urandom_range(9, 39);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Outcome check: each transfer on m_axis against the oldest owed outcome
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : outcome_check
    result_t due;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (best_match_due.size() == 0) begin
        report_mismatch("unexpected result, best_slot", m_axis_tdata[5:0], 0);
      end else begin
        due = best_match_due.pop_front();
        if (m_axis_tdata[5:0] !== due.slot) begin
          report_mismatch("best_slot", m_axis_tdata[5:0], due.slot);
        end
        if (m_axis_tdata[16:6] !== due.points) begin
          report_mismatch("best_points", m_axis_tdata[16:6], due.points);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int   i;
    int   k;
    int   lists;
    int   len;
    bit   cfg_open;
    row_t row;

    // Under the reset request (0 x 0, depth 0, 60 Hz)
    add_row(make_cand(0, 0, 0, 60, 1, 1, 1), 1, 0, 1375);                  // top score
    add_row(make_cand(16'hFFFF, 16'hFFFF, 8'hFF, 10'h3FF, 0, 0, 1), 1, 0, 550);
    // equal scores: the first one keeps the slot
    add_row(make_cand(100, 100, 0, 60, 0, 0, 0), 0, 0, 0);
    add_row(make_cand(0, 0, 0, 60, 0, 0, 0), 0, 0, 0);
    add_row(make_cand(0, 0, 0, 60, 0, 0, 1), 1, 1, 1300);
    // refresh just outside and just inside the span
    add_row(make_cand(0, 0, 0, 260, 0, 0, 0), 0, 0, 0);
    add_row(make_cand(0, 0, 0, 259, 0, 0, 1), 0, 0, 0);
    add_row(make_cand(5, 0, 0, 0, 0, 1, 1), 0, 0, 0);
    // Largest request; upper data bits of depth and refresh are dropped
    add_cfg(dmbm_pkg::REG_WANT_WIDTH,   16'hFFFF);
    add_cfg(dmbm_pkg::REG_WANT_HEIGHT,  16'hFFFF);
    add_cfg(dmbm_pkg::REG_WANT_DEPTH,   16'hFFFF);
    add_cfg(dmbm_pkg::REG_WANT_REFRESH, 16'hFFFF);
    add_row(make_cand(0, 0, 0, 0, 0, 0, 1), 1, 0, 250);                    // bottom score
    add_row(make_cand(16'hFFFF, 16'hFFFF, 8'hFF, 10'h3FF, 1, 1, 1), 1, 0, 1375);
    add_row(make_cand(16'hFFFF, 0, 8'hFF, 10'h3FF, 0, 0, 1), 0, 0, 0);
    add_row(make_cand(16'hFFFF, 16'hFFFF, 8'hFE, 823, 0, 1, 0), 0, 0, 0);
    add_row(make_cand(16'hFFFF, 16'hFFFF, 8'hFF, 824, 1, 0, 0), 0, 0, 0);
    add_row(make_cand(0, 16'hFFFF, 0, 10'h3FF, 1, 1, 1), 0, 0, 0);
    // A common desktop request
    add_cfg(dmbm_pkg::REG_WANT_WIDTH,   640);
    add_cfg(dmbm_pkg::REG_WANT_HEIGHT,  480);
    add_cfg(dmbm_pkg::REG_WANT_DEPTH,   16);
    add_cfg(dmbm_pkg::REG_WANT_REFRESH, 75);
    add_row(make_cand(640, 480, 16, 75, 0, 0, 0), 0, 0, 0);
    add_row(make_cand(800, 600, 32, 60, 1, 1, 0), 0, 0, 0);
    add_row(make_cand(639, 480, 8, 75, 1, 1, 1), 0, 0, 0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table; register writes only once the pipe is empty
    cfg_open = 1'b0;
    for (i = 0; i < directed_rows.size(); i++) begin
      row = directed_rows[i];
      if (row.is_cfg) begin
        if (!cfg_open) wait_results_settled();
        write_reg(row.reg_idx, row.reg_val);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) begin
          cfg_we_i <= 1'b0;
          cfg_open = 1'b0;
        end
        maybe_pause();
        send_candidate(row.cand, row.typed, row.res);
      end
    end

    // Random phases: new request, then a few lists, some longer than the table
    while (modes_sent < 500) begin
      wait_results_settled();
      program_request();
      no_gaps = ($urandom_range(0, 3) == 0);
      lists   = $urandom_range(1, 4);
      for (i = 0; i < lists; i++) begin
        len = ($urandom_range(0, 11) == 0) ? $urandom_range(LIST_CAP - 4, LIST_CAP + 11)
                                            : $urandom_range(1, 8);
        for (k = 0; k < len; k++) begin
          maybe_pause();
          send_candidate(random_candidate(k == len - 1), 1'b0, '0);
        end
      end
    end

    wait_results_settled();
    repeat (10) @(posedge clk_i);
    if (best_match_due.size() != 0) begin
      report_mismatch("results never delivered", 0, best_match_due.size());
    end
    if (mismatch_count == 0) begin
      $display("PASS display_mode_best_match_core");
    end else begin
      $display("FAIL display_mode_best_match_core");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/dmbm_pkg.sv
sv/dmbm_front.sv
sv/dmbm_queue.sv
sv/dmbm_back.sv
sv/display_mode_best_match_core.sv
sv/dmbm_checker.sv
verif/tb_display_mode_best_match_core.sv
